// ===== rtl/c3k_pkg.sv =====
// Shared constants, types and helpers for the 3x3 fixed-kernel convolution core.
`timescale 1ns / 1ps
package c3k_pkg;

    localparam int PIX_W       = 16;
    localparam int CONV_W      = 19;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 10;
    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_DIM     = 3;
    localparam int LS_AW       = $clog2(MAX_WIDTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(4);
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(4);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int EMIT_N      = 4;
    localparam int EMIT_INNER  = 0;
    localparam int EMIT_RIGHT  = 1;
    localparam int EMIT_BOTTOM = 2;
    localparam int EMIT_CORNER = 3;

    typedef logic [EMIT_N-1:0] emit_mask_t;

    typedef struct packed {
        logic signed [CONV_W-1:0] conv;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        emit_mask_t               mask;
    } job_t;

    function automatic logic signed [CONV_W-1:0] sext_pix(input logic signed [PIX_W-1:0] v);
        return CONV_W'(v);
    endfunction

endpackage

// ===== rtl/c3k_front.sv =====
// Front end: pixel intake, position counters, line stores, window and job forming.
`timescale 1ns / 1ps
module c3k_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [c3k_pkg::PIX_W-1:0]  s_pixel_value,
    input  logic [c3k_pkg::COL_W-1:0]         width_m1,
    input  logic [c3k_pkg::ROW_W-1:0]         height_m1,
    input  logic [c3k_pkg::QCNT_W-1:0]        queue_count,
    output logic                              push,
    output c3k_pkg::job_t                     job
);
    import c3k_pkg::*;

    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [COL_W-1:0] col_count_reg, col_count_next;

    logic                     s1_valid_reg;
    logic signed [PIX_W-1:0]  s1_px_reg;
    logic [ROW_W-1:0]         s1_row_reg;
    logic [COL_W-1:0]         s1_col_reg;
    emit_mask_t               s1_mask_reg;
    logic                     s1_interior_reg;

    logic [2*PIX_W-1:0]       line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]       line_rd_reg;

    logic signed [PIX_W-1:0]  win_reg [9];
    logic signed [PIX_W-1:0]  win_next [9];

    logic                     accept;
    logic [ROW_W-1:0]         cur_row;
    logic [COL_W-1:0]         cur_col;
    logic                     last_col;
    logic                     last_row;
    emit_mask_t               cur_mask;
    logic [QCNT_W:0]          pending;
    logic signed [CONV_W-1:0] sum;

    assign pending = {1'b0, queue_count} + (QCNT_W + 1)'(s1_valid_reg);
    assign s_ready = pending < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept  = s_valid && s_ready;

    assign cur_col  = (col_count_reg > width_m1) ? width_m1 : col_count_reg;
    assign cur_row  = (row_count_reg > height_m1) ? height_m1 : row_count_reg;
    assign last_col = (cur_col == width_m1);
    assign last_row = (cur_row == height_m1);

    always_comb begin
        cur_mask              = '0;
        cur_mask[EMIT_INNER]  = (cur_row != '0) && (cur_col != '0);
        cur_mask[EMIT_RIGHT]  = (cur_row != '0) && last_col;
        cur_mask[EMIT_BOTTOM] = last_row && (cur_col != '0);
        cur_mask[EMIT_CORNER] = last_row && last_col;
    end

    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (accept) begin
            if (last_col) begin
                col_count_next = '0;
                row_count_next = last_row ? '0 : cur_row + ROW_W'(1);
            end else begin
                col_count_next = cur_col + COL_W'(1);
                row_count_next = cur_row;
            end
        end
    end

    always_comb begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = line_rd_reg[2*PIX_W-1:PIX_W];
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = line_rd_reg[PIX_W-1:0];
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_px_reg;
    end

    assign sum = sext_pix(win_next[0]) + sext_pix(win_next[2]) + sext_pix(win_next[4])
               + sext_pix(win_next[6]) + sext_pix(win_next[8]);

    assign push     = s1_valid_reg && (s1_mask_reg != '0);
    assign job.conv = s1_interior_reg ? sum : '0;
    assign job.row  = s1_row_reg;
    assign job.col  = s1_col_reg;
    assign job.mask = s1_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            s1_valid_reg  <= accept;
            if (s1_valid_reg) begin
                for (int i = 0; i < 9; i++) begin
                    win_reg[i] <= win_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_px_reg       <= s_pixel_value;
            s1_row_reg      <= cur_row;
            s1_col_reg      <= cur_col;
            s1_mask_reg     <= cur_mask;
            s1_interior_reg <= (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
        end
    end

    // The older row takes the newer row's old value; the newer row takes the pixel.
    always_ff @(posedge aclk) begin
        if (accept) begin
            line_rd_reg <= line_mem[cur_col[LS_AW-1:0]];
        end
        if (s1_valid_reg) begin
            line_mem[s1_col_reg[LS_AW-1:0]] <= {line_rd_reg[PIX_W-1:0], s1_px_reg};
        end
    end

endmodule

// ===== rtl/c3k_fifo.sv =====
// Short job queue between the front end and the result sequencer.
`timescale 1ns / 1ps
module c3k_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  c3k_pkg::job_t               wr_job,
    input  logic                        pop,
    output c3k_pkg::job_t               head,
    output logic                        not_empty,
    output logic [c3k_pkg::QCNT_W-1:0]  count
);
    import c3k_pkg::*;

    job_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = queue_mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== rtl/c3k_back.sv =====
// Back end: expands each job into its results and holds them in the output register.
`timescale 1ns / 1ps
module c3k_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  c3k_pkg::job_t                      head,
    input  logic                               head_valid,
    output logic                               pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [c3k_pkg::CONV_W-1:0]  m_conv_value,
    output logic [c3k_pkg::ROW_W-1:0]          m_out_row,
    output logic [c3k_pkg::COL_W-1:0]          m_out_col,
    output logic                               m_last_of_item,
    output logic                               m_last_of_frame
);
    import c3k_pkg::*;

    job_t                     job_reg;
    emit_mask_t               rem_reg, rem_next;
    emit_mask_t               sel;
    emit_mask_t               rem_after;
    logic                     work_valid;
    logic                     out_free;
    logic                     emit;

    logic                     m_valid_reg, m_valid_next;
    logic signed [CONV_W-1:0] conv_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [COL_W-1:0]         col_reg;
    logic                     last_item_reg;
    logic                     last_frame_reg;

    assign work_valid = (rem_reg != '0);
    assign sel        = rem_reg & (~rem_reg + EMIT_N'(1));
    assign rem_after  = rem_reg & ~sel;
    assign out_free   = !m_valid_reg || m_ready;
    assign emit       = work_valid && out_free;
    assign pop        = head_valid && (!work_valid || (emit && (rem_after == '0)));

    always_comb begin
        rem_next = rem_reg;
        if (pop) begin
            rem_next = head.mask;
        end else if (emit) begin
            rem_next = rem_after;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= head;
        end
        if (emit) begin
            conv_reg       <= sel[EMIT_INNER] ? job_reg.conv : '0;
            row_reg        <= (sel[EMIT_INNER] || sel[EMIT_RIGHT]) ? job_reg.row - ROW_W'(1)
                            : job_reg.row;
            col_reg        <= (sel[EMIT_INNER] || sel[EMIT_BOTTOM]) ? job_reg.col - COL_W'(1)
                            : job_reg.col;
            last_item_reg  <= (rem_after == '0);
            last_frame_reg <= sel[EMIT_CORNER];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_conv_value    = conv_reg;
    assign m_out_row       = row_reg;
    assign m_out_col       = col_reg;
    assign m_last_of_item  = last_item_reg;
    assign m_last_of_frame = last_frame_reg;

endmodule

// ===== rtl/conv3x3_fixed_kernel_stream_core.sv =====
// Top level of the 3x3 fixed-kernel streaming convolution core with its register port.
// Path: stage-1, queue, job register, output register. Throughput: one pixel per cycle
// while s_ready is high; the output sends one result per cycle while m_ready is high, so
// row-end pixels (two results) and last-row pixels (up to four) draw on the job queue.
// Reset clears the counters, window, queue, output register and registers (4 x 4 frame);
// the line stores are not cleared and hold their contents until overwritten.
`timescale 1ns / 1ps
module conv3x3_fixed_kernel_stream_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [c3k_pkg::PIX_W-1:0]       s_pixel_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [c3k_pkg::CONV_W-1:0]      m_conv_value,
    output logic [c3k_pkg::ROW_W-1:0]              m_out_row,
    output logic [c3k_pkg::COL_W-1:0]              m_out_col,
    output logic                                   m_last_of_item,
    output logic                                   m_last_of_frame,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [c3k_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [c3k_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [c3k_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);
    import c3k_pkg::*;

    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]        width_m1;
    logic [ROW_W-1:0]        height_m1;
    logic                    cfg_write;

    job_t                    front_job;
    job_t                    head_job;
    logic                    push;
    logic                    pop;
    logic                    head_valid;
    logic [QCNT_W-1:0]       queue_count;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_WIDTH) begin
                width_reg <= pwdata[CFG_WIDTH_W-1:0];
            end else begin
                height_reg <= pwdata[CFG_HEIGHT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_HEIGHT) ? APB_DATA_W'(height_reg) : APB_DATA_W'(width_reg);

    always_comb begin
        if (width_reg < CFG_WIDTH_W'(MIN_DIM)) begin
            width_m1 = COL_W'(MIN_DIM - 1);
        end else if (width_reg > CFG_WIDTH_W'(MAX_WIDTH)) begin
            width_m1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            width_m1 = COL_W'(width_reg - CFG_WIDTH_W'(1));
        end
        if (height_reg < CFG_HEIGHT_W'(MIN_DIM)) begin
            height_m1 = ROW_W'(MIN_DIM - 1);
        end else if (height_reg > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
            height_m1 = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            height_m1 = ROW_W'(height_reg - CFG_HEIGHT_W'(1));
        end
    end

    c3k_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .width_m1      (width_m1),
        .height_m1     (height_m1),
        .queue_count   (queue_count),
        .push          (push),
        .job           (front_job)
    );

    c3k_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_job    (front_job),
        .pop       (pop),
        .head      (head_job),
        .not_empty (head_valid),
        .count     (queue_count)
    );

    c3k_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (head_job),
        .head_valid      (head_valid),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_conv_value    (m_conv_value),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_last_of_item  (m_last_of_item),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule
